// ===== hw/rtl/srtf_preemptive_schedule_unit_assert.svh =====
// ----------------------------------------------------------------------------
// srtf assertion macros
// concurrent checks for the scheduler rtl, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULE_UNIT_ASSERT_SVH
`define SRTF_PREEMPTIVE_SCHEDULE_UNIT_ASSERT_SVH

// same-cycle implication
`define SRTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf package
// shared types and constants of the shortest-remaining-time-first scheduler
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int TIME_W       = 24;
  localparam int VAL_W        = 16;
  localparam int JOB_IDX_W    = 6;

  typedef struct packed {
    logic [VAL_W-1:0] burst_time;
    logic [VAL_W-1:0] arrival_tick;
    logic             last_job;
  } job_item_t;

  typedef struct packed {
    logic [JOB_IDX_W-1:0] job_index;
    logic [TIME_W-1:0]    finish_tick;
    logic [TIME_W-1:0]    wait_ticks;
    logic [TIME_W-1:0]    turnaround_ticks;
    logic                 last_result;
  } result_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pre_init;
    logic pre_next;
    logic emit_zero;
    logic scan_init;
    logic idle_jump;
    logic commit;
    logic emit_run;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pre_zero;
    logic pre_last;
    logic out_free;
    logic scan_end;
    logic best_valid;
    logic best_finishes;
    logic has_next;
    logic all_done;
  } status_t;

endpackage

// ===== hw/rtl/srtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// srtf controller
// sequences loading, the zero-burst pass and the per-segment scheduling scans
// ----------------------------------------------------------------------------
module srtf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  logic              load_last,
  output logic              load_ready,
  input  srtf_pkg::status_t sts,
  output srtf_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_PRE_RD    = 9'b000000010,
    S_PRE_CHK   = 9'b000000100,
    S_PRE_EMIT  = 9'b000001000,
    S_CHECK     = 9'b000010000,
    S_SCAN_INIT = 9'b000100000,
    S_SCAN      = 9'b001000000,
    S_DECIDE    = 9'b010000000,
    S_EMIT      = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    load_ready = 1'b0;
    case (state)
      S_IDLE: begin
        load_ready = 1'b1;
        if (load_valid) begin
          cmd.load = 1'b1;
          if (load_last) begin
            cmd.pre_init = 1'b1;
            state_next   = S_PRE_RD;
          end
        end
      end
      S_PRE_RD: begin
        state_next = S_PRE_CHK;
      end
      S_PRE_CHK: begin
        if (sts.pre_zero) begin
          state_next = S_PRE_EMIT;
        end else if (sts.pre_last) begin
          state_next = S_CHECK;
        end else begin
          cmd.pre_next = 1'b1;
          state_next   = S_PRE_RD;
        end
      end
      S_PRE_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_zero = 1'b1;
          if (sts.pre_last) begin
            state_next = S_CHECK;
          end else begin
            cmd.pre_next = 1'b1;
            state_next   = S_PRE_RD;
          end
        end
      end
      S_CHECK: begin
        if (sts.all_done) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.best_valid) begin
          cmd.idle_jump = 1'b1;
          state_next    = S_SCAN_INIT;
        end else begin
          cmd.commit = 1'b1;
          state_next = sts.best_finishes ? S_EMIT : S_SCAN_INIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_run = 1'b1;
          state_next   = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/srtf_dp.sv =====
// ----------------------------------------------------------------------------
// srtf datapath
// job memories, scan pipeline, simulated clock and result register
// ----------------------------------------------------------------------------
module srtf_dp #(
  parameter int MaxJobs = srtf_pkg::MAX_JOBS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  srtf_pkg::cmd_t         cmd,
  input  srtf_pkg::job_item_t    load_item,
  output srtf_pkg::status_t      sts,
  output logic                   result_valid,
  input  logic                   result_ready,
  output srtf_pkg::result_item_t result_item
);

  localparam int IdxW  = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int CntW  = $clog2(MaxJobs + 1);
  localparam int VW    = srtf_pkg::VAL_W;
  localparam int TW    = srtf_pkg::TIME_W;

  logic [VW-1:0] burst_mem   [MaxJobs];
  logic [VW-1:0] arrival_mem [MaxJobs];
  logic [VW-1:0] rem_mem     [MaxJobs];

  logic [VW-1:0]   rd_burst, rd_arr, rd_rem;
  logic [CntW-1:0] load_cnt, done_cnt;
  logic [TW-1:0]   tick;
  logic [IdxW-1:0] scan_idx, eval_idx, best_idx, run_idx;
  logic            issue_act, eval_act, eval_last;
  logic            run_valid, best_valid, have_next;
  logic [VW-1:0]   run_rem, run_arr, run_burst;
  logic [VW-1:0]   best_rem, best_arr, best_burst, next_arr;
  logic [VW:0]     sum_ab;

  logic            room;
  logic            rem_we;
  logic [IdxW-1:0] rem_addr, load_addr;
  logic [VW-1:0]   rem_wdata;
  logic [VW-1:0]   gap, step;
  logic            cut;
  logic [TW:0]     tick_sum;
  logic [TW-1:0]   tick_next;
  logic            scan_is_last;
  logic            eval_ready;
  logic [TW:0]     late_diff;
  logic            late;
  logic            last_flag;

  assign room      = load_cnt < CntW'(MaxJobs);
  assign load_addr = load_cnt[IdxW-1:0];

  // gap to the next arrival, only meaningful while one is pending
  assign gap       = next_arr - tick[VW-1:0];
  assign cut       = have_next && (gap < best_rem);
  assign step      = cut ? gap : best_rem;
  assign tick_sum  = {1'b0, tick} + (TW+1)'(step);
  assign tick_next = tick_sum[TW] ? '1 : tick_sum[TW-1:0];

  assign rem_we    = (cmd.load && room) || cmd.commit;
  assign rem_addr  = cmd.commit ? best_idx : load_addr;
  assign rem_wdata = cmd.commit ? best_rem - step : load_item.burst_time;

  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      burst_mem[load_addr]   <= load_item.burst_time;
      arrival_mem[load_addr] <= load_item.arrival_tick;
    end
    if (rem_we) begin
      rem_mem[rem_addr] <= rem_wdata;
    end
    rd_burst <= burst_mem[scan_idx];
    rd_arr   <= arrival_mem[scan_idx];
    rd_rem   <= rem_mem[scan_idx];
  end

  assign scan_is_last = (CntW'(scan_idx) + CntW'(1)) == load_cnt;
  assign eval_ready   = ({{(TW-VW){1'b0}}, rd_arr} <= tick);

  // scan pipeline and per-run state
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_act <= 1'b0;
      eval_act  <= 1'b0;
      load_cnt  <= '0;
      done_cnt  <= '0;
      tick      <= '0;
      run_valid <= 1'b0;
      run_idx   <= '0;
      scan_idx  <= '0;
    end else begin
      eval_act <= issue_act;
      if (issue_act) begin
        eval_idx  <= scan_idx;
        eval_last <= scan_is_last;
        if (scan_is_last) begin
          issue_act <= 1'b0;
        end else begin
          scan_idx <= scan_idx + IdxW'(1);
        end
      end
      if (cmd.load && room) begin
        load_cnt <= load_cnt + CntW'(1);
      end
      if (cmd.pre_init) begin
        scan_idx <= '0;
      end
      if (cmd.pre_next) begin
        scan_idx <= scan_idx + IdxW'(1);
      end
      if (cmd.scan_init) begin
        scan_idx   <= '0;
        issue_act  <= 1'b1;
        best_valid <= run_valid;
        best_idx   <= run_idx;
        best_rem   <= run_rem;
        best_arr   <= run_arr;
        best_burst <= run_burst;
        have_next  <= 1'b0;
      end
      if (eval_act && (rd_rem != '0)) begin
        if (eval_ready) begin
          if (!best_valid || (rd_rem < best_rem)) begin
            best_valid <= 1'b1;
            best_idx   <= eval_idx;
            best_rem   <= rd_rem;
            best_arr   <= rd_arr;
            best_burst <= rd_burst;
          end
        end else if (!have_next || (rd_arr < next_arr)) begin
          have_next <= 1'b1;
          next_arr  <= rd_arr;
        end
      end
      if (cmd.idle_jump) begin
        tick <= {{(TW-VW){1'b0}}, next_arr};
      end
      if (cmd.commit) begin
        tick   <= tick_next;
        sum_ab <= {1'b0, best_arr} + {1'b0, best_burst};
        if (cut) begin
          run_valid <= 1'b1;
          run_idx   <= best_idx;
          run_rem   <= best_rem - step;
          run_arr   <= best_arr;
          run_burst <= best_burst;
        end else begin
          run_valid <= 1'b0;
        end
      end
      if (cmd.emit_zero || cmd.emit_run) begin
        done_cnt <= done_cnt + CntW'(1);
      end
      if (cmd.clear) begin
        load_cnt  <= '0;
        done_cnt  <= '0;
        tick      <= '0;
        run_valid <= 1'b0;
        run_idx   <= '0;
      end
    end
  end

  // result math: wait clamps at zero, turnaround is finish minus arrival when late
  assign late_diff = {1'b0, tick} - {{(TW-VW){1'b0}}, sum_ab};
  assign late      = !late_diff[TW] && (late_diff != '0);
  assign last_flag = (done_cnt + CntW'(1)) == load_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_zero || cmd.emit_run) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      result_item.job_index        <= srtf_pkg::JOB_IDX_W'(scan_idx);
      result_item.finish_tick      <= {{(TW-VW){1'b0}}, rd_arr};
      result_item.wait_ticks       <= '0;
      result_item.turnaround_ticks <= '0;
      result_item.last_result      <= last_flag;
    end else if (cmd.emit_run) begin
      result_item.job_index        <= srtf_pkg::JOB_IDX_W'(best_idx);
      result_item.finish_tick      <= tick;
      result_item.wait_ticks       <= late ? late_diff[TW-1:0] : '0;
      result_item.turnaround_ticks <= late ? tick - {{(TW-VW){1'b0}}, best_arr}
                                           : {{(TW-VW){1'b0}}, best_burst};
      result_item.last_result      <= last_flag;
    end
  end

  assign sts.pre_zero      = (rd_rem == '0);
  assign sts.pre_last      = scan_is_last;
  assign sts.out_free      = !result_valid || result_ready;
  assign sts.scan_end      = eval_act && eval_last;
  assign sts.best_valid    = best_valid;
  assign sts.best_finishes = !cut;
  assign sts.has_next      = have_next;
  assign sts.all_done      = (done_cnt == load_cnt);

endmodule

// ===== hw/rtl/srtf_preemptive_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// srtf preemptive schedule unit
// loads a job set and reports completions of a preemptive shortest remaining
// time first schedule over it
// ----------------------------------------------------------------------------
//  channel  | signals                               | item
//  ---------+---------------------------------------+--------------------------
//  load     | load_valid, load_ready, load_item     | burst, arrival, last flag
//  result   | result_valid, result_ready, result_item | one completed job
//
//  a job without the last flag is only stored; the last job starts a run:
//  a zero-burst pass reads and checks each job and emits the zero-burst ones,
//  then scans read every job through the single read port of the job memories,
//  then a decide and, on a completion, an emit; at most 2n scans for n jobs
//  a stalled result holds the run at its next completion; load_ready is high
//  only between runs. rst is synchronous and empties the job set
// ----------------------------------------------------------------------------
`include "srtf_preemptive_schedule_unit_assert.svh"

module srtf_preemptive_schedule_unit #(
  parameter int MaxJobs = srtf_pkg::MAX_JOBS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_valid,
  output logic                   load_ready,
  input  srtf_pkg::job_item_t    load_item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output srtf_pkg::result_item_t result_item
);

  srtf_pkg::cmd_t    cmd;
  srtf_pkg::status_t sts;

  // sequencer: load, zero-burst pass, scan / decide / emit loop
  srtf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .load_valid (load_valid),
    .load_last  (load_item.last_job),
    .load_ready (load_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // job memories, simulated clock, best-job search and result register
  srtf_dp #(
    .MaxJobs (MaxJobs)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .load_item    (load_item),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  // a segment is only committed once the scan found a ready job
  `SRTF_ASSERT_NOW(a_commit_has_best, cmd.commit, sts.best_valid, "commit without ready job")

  // results never overwrite one that is still waiting
  `SRTF_ASSERT_NOW(a_emit_slot_free, cmd.emit_run || cmd.emit_zero, sts.out_free,
                   "result emitted into a full output register")

  // idling is only allowed toward a pending arrival
  `SRTF_ASSERT_NOW(a_idle_has_next, cmd.idle_jump, sts.has_next, "idle with no pending arrival")

  // an emitted item shows up as a valid result in the next cycle
  `SRTF_ASSERT_NEXT(a_emit_shows, cmd.emit_run || cmd.emit_zero, result_valid,
                    "emitted result not presented")

endmodule

// ===== verif/tb_srtf_preemptive_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// srtf preemptive schedule unit testbench
// loads job sets over the load channel and checks every reported completion
// against an in-bench shortest remaining time first schedule, under several
// handshake idling mixes, a long result hold-off and store overflow
// ----------------------------------------------------------------------------
module tb_srtf_preemptive_schedule_unit;

  localparam int     JOB_SLOTS     = srtf_pkg::MAX_JOBS_DEF;
  localparam int     VW            = srtf_pkg::VAL_W;
  localparam int     TW            = srtf_pkg::TIME_W;
  localparam int     IW            = srtf_pkg::JOB_IDX_W;
  localparam longint TIME_TOP      = (64'd1 << TW) - 1;
  localparam int     CYCLE_LIMIT   = 400000;
  // settle time for the clear back to idle after the last completion
  localparam int     SETTLE_CYCLES = 64;

  logic                   clk;
  logic                   rst;
  logic                   load_valid;
  logic                   load_ready;
  srtf_pkg::job_item_t    load_item;
  logic                   result_valid;
  logic                   result_ready;
  srtf_pkg::result_item_t result_item;

  srtf_preemptive_schedule_unit #(
    .MaxJobs(JOB_SLOTS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (load_valid),
    .load_ready  (load_ready),
    .load_item   (load_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item (result_item)
  );

  // job set as the block holds it, in load order
  logic [VW-1:0] held_burst   [JOB_SLOTS];
  logic [VW-1:0] held_arrival [JOB_SLOTS];
  int            jobs_held = 0;

  // completions the schedule says are still to come, oldest first
  srtf_pkg::result_item_t pending_completions [$];
  srtf_pkg::result_item_t oldest_completion;

  int send_idle_pct       = 0;
  int recv_stall_pct      = 0;
  int hold_left           = 0;
  int errors              = 0;
  int items_sent          = 0;
  int sets_started        = 0;
  int completions_checked = 0;
  int cycle_count         = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("srtf_preemptive_schedule_unit test failed");
    $finish;
  end

  function automatic longint sat_time(longint v);
    return (v > TIME_TOP) ? TIME_TOP : v;
  endfunction

  // one completion: wait is clamped at zero, all times saturate
  task automatic push_completion(int idx, longint finish, bit is_last);
    longint                 b;
    longint                 a;
    longint                 wt;
    longint                 ta;
    longint                 fin;
    srtf_pkg::result_item_t r;
    b   = held_burst[idx];
    a   = held_arrival[idx];
    fin = sat_time(finish);
    wt  = sat_time((fin > a + b) ? fin - a - b : 0);
    ta  = sat_time(b + wt);
    r.job_index        = idx[IW-1:0];
    r.finish_tick      = fin[TW-1:0];
    r.wait_ticks       = wt[TW-1:0];
    r.turnaround_ticks = ta[TW-1:0];
    r.last_result      = is_last;
    pending_completions.push_back(r);
  endtask

  // segment-wise srtf over the held set: a segment runs the chosen job until
  // it finishes or the next arrival, whichever comes first
  task automatic schedule_set();
    int            count;
    int            done;
    int            best;
    int            run_job;
    int            i;
    bit            run_valid;
    bit            have_next;
    longint        tick;
    longint        next_arr;
    longint        d;
    logic [VW-1:0] left [JOB_SLOTS];
    count     = jobs_held;
    done      = 0;
    tick      = 0;
    run_valid = 1'b0;
    run_job   = 0;
    for (i = 0; i < count; i++) left[i] = held_burst[i];
    // zero-burst jobs never run and are reported first, in index order
    for (i = 0; i < count; i++) begin
      if (left[i] == 0) begin
        push_completion(i, held_arrival[i], done + 1 == count);
        done++;
      end
    end
    while (done < count) begin
      best      = -1;
      have_next = 1'b0;
      next_arr  = 0;
      // the running job keeps the processor on a tie
      if (run_valid && left[run_job] > 0) best = run_job;
      for (i = 0; i < count; i++) begin
        if (left[i] != 0) begin
          if (held_arrival[i] <= tick) begin
            if (best < 0 || left[i] < left[best]) best = i;
          end else if (!have_next || held_arrival[i] < next_arr) begin
            next_arr  = held_arrival[i];
            have_next = 1'b1;
          end
        end
      end
      if (best < 0) begin
        // idle until the next arrival
        tick = next_arr;
        continue;
      end
      d = left[best];
      if (have_next && next_arr - tick < d) d = next_arr - tick;
      left[best] = left[best] - d[VW-1:0];
      tick       = sat_time(tick + d);
      run_job    = best;
      run_valid  = 1'b1;
      if (left[best] == 0) begin
        push_completion(best, tick, done + 1 == count);
        done++;
        run_valid = 1'b0;
      end
    end
    jobs_held = 0;
  endtask

  // accepted job: stored unless the set is full; the last flag starts a run
  task automatic record_job(srtf_pkg::job_item_t it);
    if (jobs_held < JOB_SLOTS) begin
      held_burst[jobs_held]   = it.burst_time;
      held_arrival[jobs_held] = it.arrival_tick;
      jobs_held++;
    end
    if (it.last_job) begin
      sets_started++;
      schedule_set();
    end
  endtask

  // offer one job item, called and returning at a falling edge
  task automatic send_job(logic [VW-1:0] burst, logic [VW-1:0] arrival,
                          bit last);
    srtf_pkg::job_item_t it;
    it.burst_time   = burst;
    it.arrival_tick = arrival;
    it.last_job     = last;
    while ($urandom_range(99) < send_idle_pct) begin
      load_valid = 1'b0;
      @(negedge clk);
    end
    load_valid = 1'b1;
    load_item  = it;
    @(posedge clk);
    while (!load_ready) @(posedge clk);
    record_job(it);
    items_sent++;
    @(negedge clk);
    load_valid = 1'b0;
  endtask

  // sender pause: hold off until every completion is in, then let the
  // block settle back to idle
  task automatic wait_all_done();
    while (pending_completions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // result side: random stalls, or a counted hold-off when one is requested
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ready = 1'b0;
      end else begin
        result_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // completion check against the oldest pending one
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_completions.size() == 0) begin
        $display("%0t: unexpected completion job %0d finish %0d wait %0d",
                 $time, result_item.job_index, result_item.finish_tick,
                 result_item.wait_ticks);
        errors++;
      end else begin
        oldest_completion = pending_completions.pop_front();
        completions_checked++;
        if (result_item !== oldest_completion) begin
          $display("%0t: completion mismatch, expected job %0d finish %0d wait %0d",
                   $time, oldest_completion.job_index,
                   oldest_completion.finish_tick, oldest_completion.wait_ticks);
          $display("    turnaround %0d last %0b, got job %0d finish %0d wait %0d",
                   oldest_completion.turnaround_ticks,
                   oldest_completion.last_result, result_item.job_index,
                   result_item.finish_tick, result_item.wait_ticks);
          $display("    turnaround %0d last %0b", result_item.turnaround_ticks,
                   result_item.last_result);
          errors++;
        end
      end
    end
  end

  // one-job sets at the field extremes, zero burst among them
  task automatic test_single_jobs();
    send_job(16'd0, 16'd0, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    send_job(16'd1, 16'd0, 1'b1);
    wait_all_done();
  endtask

  // a shorter arrival preempts, an equal remainder does not, and equal
  // bursts go to the lower index
  task automatic test_preemption_and_ties();
    send_job(16'd10, 16'd0, 1'b0);
    send_job(16'd2, 16'd3, 1'b1);
    send_job(16'd5, 16'd0, 1'b0);
    send_job(16'd3, 16'd2, 1'b1);
    send_job(16'd4, 16'd0, 1'b0);
    send_job(16'd4, 16'd0, 1'b1);
    wait_all_done();
  endtask

  // nothing ready at tick zero, and zero-burst jobs mixed into a set
  task automatic test_idle_gaps_and_zero_burst();
    send_job(16'd3, 16'd100, 1'b0);
    send_job(16'd2, 16'd50, 1'b1);
    send_job(16'd5, 16'd0, 1'b0);
    send_job(16'd0, 16'd7, 1'b0);
    send_job(16'd2, 16'd1, 1'b0);
    send_job(16'd0, 16'd3, 1'b1);
    wait_all_done();
  endtask

  // jobs past a full store are dropped, the dropped last one still starts
  task automatic test_store_overflow();
    int k;
    for (k = 0; k < JOB_SLOTS + 2; k++) begin
      send_job(16'($urandom_range(30)), 16'($urandom_range(40)),
               k == JOB_SLOTS + 1);
    end
    wait_all_done();
  endtask

  // random sets, mostly small, a few full or overflowing
  task automatic test_random_sets(int item_goal, int idle_pct, int stall_pct);
    int            loaded;
    int            set_size;
    int            roll;
    int            k;
    logic [VW-1:0] b;
    logic [VW-1:0] a;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    loaded         = 0;
    while (loaded < item_goal) begin
      roll = $urandom_range(99);
      if (roll < 65) set_size = $urandom_range(6, 1);
      else if (roll < 92) set_size = $urandom_range(16, 7);
      else set_size = $urandom_range(20, 17);
      for (k = 0; k < set_size; k++) begin
        roll = $urandom_range(99);
        if (roll < 25) b = 16'($urandom_range(12));
        else if (roll < 80) b = 16'($urandom_range(400, 1));
        else b = 16'($urandom_range(65535));
        roll = $urandom_range(99);
        if (roll < 35) a = 16'($urandom_range(15));
        else if (roll < 80) a = 16'($urandom_range(600));
        else a = 16'($urandom_range(65535));
        send_job(b, a, k == set_size - 1);
        if (k < JOB_SLOTS) loaded++;
      end
    end
    wait_all_done();
  endtask

  // long result hold-off while sets keep coming, so the load side stalls
  task automatic test_result_backpressure();
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    test_random_sets(50, 0, 0);
  endtask

  initial begin
    rst        = 1'b1;
    load_valid = 1'b0;
    load_item  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_jobs();
    test_preemption_and_ties();
    test_idle_gaps_and_zero_burst();
    test_store_overflow();
    test_random_sets(95, 0, 0);
    test_random_sets(95, 59, 0);
    test_random_sets(95, 0, 59);
    test_random_sets(95, 12, 12);
    test_result_backpressure();

    $display("ran %0d job items in %0d sets, %0d completions checked",
             items_sent, sets_started, completions_checked);
    $display("covered corners, preemption, ties, idle gaps, overflow and stalls");
    if (errors == 0 && pending_completions.size() == 0) begin
      $display("srtf_preemptive_schedule_unit test passed");
    end else begin
      $display("srtf_preemptive_schedule_unit test failed");
    end
    $finish;
  end

endmodule
